// ----- hdl/dd_pkg.sv -----
// ----------------------------------------------------------------------------
// dd_pkg
// shared types, constants and calendar tables for the date difference block
// ----------------------------------------------------------------------------
package dd_pkg;

  localparam int DayW     = 5;
  localparam int MonthW   = 4;
  localparam int YearW    = 14;
  localparam int DistW    = 22;
  localparam int DayNumW  = 23;
  localparam int Quart4W  = YearW - 2;
  localparam int ProdW    = 25;
  localparam int Q100W    = 8;
  localparam int Q400W    = Q100W - 2;
  localparam int OffsetW  = 9;

  // reciprocal of 25 scaled by 2^17, exact for quotients of 12-bit values
  localparam logic [12:0] Recip25    = 13'd5243;
  localparam int          RecipShift = 17;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  // first register stage of a date: raw fields and the /25 product
  typedef struct packed {
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [Quart4W-1:0] year_q4;
    logic [ProdW-1:0]   prod;
  } split_t;

  // terms of the day number, years counted from march
  typedef struct packed {
    logic [YearW-1:0]   yy;
    logic [Quart4W-1:0] q4;
    logic [Q100W-1:0]   q100;
    logic [Q400W-1:0]   q400;
    logic [OffsetW-1:0] offset;
    logic [DayW-1:0]    day;
    logic               ok;
  } parts_t;

  // days from 1 march to the first of the month
  function automatic logic [OffsetW-1:0] month_offset(input logic [MonthW-1:0] m);
    logic [OffsetW-1:0] o;
    case (m)
      4'd3:    o = 9'd0;
      4'd4:    o = 9'd31;
      4'd5:    o = 9'd61;
      4'd6:    o = 9'd92;
      4'd7:    o = 9'd122;
      4'd8:    o = 9'd153;
      4'd9:    o = 9'd184;
      4'd10:   o = 9'd214;
      4'd11:   o = 9'd245;
      4'd12:   o = 9'd275;
      4'd1:    o = 9'd306;
      4'd2:    o = 9'd337;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] n;
    if (m == MonthFeb) begin
      n = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      n = 5'd30;
    end else begin
      n = 5'd31;
    end
    return n;
  endfunction

endpackage

// ----- hdl/dd_year_split.sv -----
// ----------------------------------------------------------------------------
// dd_year_split
// two stages: year divided by 100, leap rule, date check and day number terms
// ----------------------------------------------------------------------------
module dd_year_split (
  input  logic           clk,
  input  logic           en,
  input  dd_pkg::date_t  date,
  output dd_pkg::parts_t parts
);
  import dd_pkg::*;

  split_t                split;
  parts_t                parts_next;
  logic [Quart4W-1:0]    q4_in;
  logic [Q100W-1:0]      q;
  logic [Quart4W-1:0]    rem;
  logic                  rem_zero;
  logic                  y4z;
  logic                  div100;
  logic                  leap;
  logic                  early;
  logic [Q100W-1:0]      q100yy;
  logic                  month_ok;

  assign q4_in = date.year[YearW-1:2];

  always_ff @(posedge clk) begin
    if (en) begin
      split.day     <= date.day;
      split.month   <= date.month;
      split.year    <= date.year;
      split.year_q4 <= q4_in;
      split.prod    <= ProdW'(q4_in) * ProdW'(Recip25);
    end
  end

  always_comb begin
    q        = split.prod[ProdW-1:RecipShift];
    rem      = split.year_q4 - Quart4W'(Quart4W'(q) * Quart4W'(25));
    rem_zero = (rem == '0);
    y4z      = (split.year[1:0] == 2'b00);
    div100   = y4z && rem_zero;
    leap     = y4z && (!rem_zero || (q[1:0] == 2'b00));
    early    = (split.month < MonthMar);
    month_ok = (split.month >= MonthJan) && (split.month <= MonthDec);
    q100yy   = q - Q100W'(early && div100);

    parts_next.yy     = split.year - YearW'(early);
    parts_next.q4     = split.year_q4 - Quart4W'(early && y4z);
    parts_next.q100   = q100yy;
    parts_next.q400   = q100yy[Q100W-1:2];
    parts_next.offset = month_offset(split.month);
    parts_next.day    = split.day;
    parts_next.ok     = (split.year != '0) && month_ok && (split.day != '0) &&
                        (split.day <= month_days(split.month, leap));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      parts <= parts_next;
    end
  end

endmodule

// ----- hdl/dd_day_count.sv -----
// ----------------------------------------------------------------------------
// dd_day_count
// one stage: sums the terms into a day number from a fixed epoch
// ----------------------------------------------------------------------------
module dd_day_count (
  input  logic                       clk,
  input  logic                       en,
  input  dd_pkg::parts_t             parts,
  output logic [dd_pkg::DayNumW-1:0] day_num,
  output logic                       ok
);
  import dd_pkg::*;

  logic [DayNumW-1:0] day_num_next;

  always_comb begin
    day_num_next = DayNumW'(parts.yy) * DayNumW'(365)
                 + DayNumW'(parts.q4)
                 + DayNumW'(parts.q400)
                 + DayNumW'(parts.offset)
                 + DayNumW'(parts.day)
                 - DayNumW'(parts.q100);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_num <= day_num_next;
      ok      <= parts.ok;
    end
  end

endmodule

// ----- hdl/date_difference_days.sv -----
// ----------------------------------------------------------------------------
// date_difference_days
// absolute day distance between two proleptic gregorian dates
// ----------------------------------------------------------------------------
// channel  dir  fields (lowest bit up)
// s_axis   in   tdata: first_day 5, first_month 4, first_year 14,
//                      second_day 5, second_month 4, second_year 14, pad 2
// m_axis   out  tdata: day_distance 22, pad 2; tuser: date_invalid 1
//
// one transaction accepted per cycle unless a result is stalled, result registered in turn through
// the stages: divide by 100 product, leap rule and checks, day number sum,
// difference with saturation into the output register
// the whole pipeline advances together and holds while a result is stalled
// rst clears the valid bits only, payload registers are left free
// ----------------------------------------------------------------------------
module date_difference_days (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_day, first_month, first_year, second_day, second_month, second_year
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // day_distance
  output logic [23:0] m_axis_tdata,
  // date_invalid
  output logic [0:0]  m_axis_tuser
);
  import dd_pkg::*;

  date_t              date_a;
  date_t              date_b;
  parts_t             parts_a;
  parts_t             parts_b;
  logic [DayNumW-1:0] num_a;
  logic [DayNumW-1:0] num_b;
  logic               ok_a;
  logic               ok_b;
  logic               adv;
  logic               v1;
  logic               v2;
  logic               v3;
  logic [DayNumW-1:0] diff;
  logic [DistW-1:0]   day_gap_next;
  logic               invalid_next;
  logic [DistW-1:0]   day_gap;
  logic               invalid;

  // every stage moves when the output register is free or being emptied
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // unpack the input transaction
  assign date_a.day   = s_axis_tdata[4:0];
  assign date_a.month = s_axis_tdata[8:5];
  assign date_a.year  = s_axis_tdata[22:9];
  assign date_b.day   = s_axis_tdata[27:23];
  assign date_b.month = s_axis_tdata[31:28];
  assign date_b.year  = s_axis_tdata[45:32];

  dd_year_split u_split_a (
    .clk   (clk),
    .en    (adv),
    .date  (date_a),
    .parts (parts_a)
  );

  dd_year_split u_split_b (
    .clk   (clk),
    .en    (adv),
    .date  (date_b),
    .parts (parts_b)
  );

  dd_day_count u_count_a (
    .clk     (clk),
    .en      (adv),
    .parts   (parts_a),
    .day_num (num_a),
    .ok      (ok_a)
  );

  dd_day_count u_count_b (
    .clk     (clk),
    .en      (adv),
    .parts   (parts_b),
    .day_num (num_b),
    .ok      (ok_b)
  );

  // valid bits alongside the payload stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      v3            <= v2;
      m_axis_tvalid <= v3;
    end
  end

  // absolute difference, clamp to the field, zero on a bad date
  always_comb begin
    diff         = (num_a >= num_b) ? (num_a - num_b) : (num_b - num_a);
    invalid_next = !(ok_a && ok_b);
    if (invalid_next) begin
      day_gap_next = '0;
    end else if (diff > DayNumW'(DistMax)) begin
      day_gap_next = DistMax;
    end else begin
      day_gap_next = diff[DistW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      day_gap <= day_gap_next;
      invalid <= invalid_next;
    end
  end

  assign m_axis_tdata = {2'b00, day_gap};
  assign m_axis_tuser = invalid;

  // a bad date never carries a distance
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[DistW-1:0] == '0))
    else $error("invalid date with non-zero distance");

  // a stalled result keeps the last stage frozen as well
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(num_a) && $stable(num_b) && $stable(v3))
    else $error("pipeline moved during a stall");

  // an accepted transaction enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted transaction lost at entry");

endmodule

// ----- tb/date_difference_days_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_difference_days_tb
// self-checking bench for the gregorian day distance block: date pairs go in
// on the slave stream, every result is compared with a day-number predictor
// ----------------------------------------------------------------------------
module date_difference_days_tb;
  import dd_pkg::*;

  // expected content of one result transaction
  typedef struct {
    logic [DistW-1:0] distance;
    logic             invalid;
  } span_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // first_day, first_month, first_year, second_day, second_month, second_year
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // day_distance
  logic [23:0] m_axis_tdata;
  // date_invalid
  logic [0:0]  m_axis_tuser;

  // expected results, oldest first
  span_t pending_spans[$];

  // idling controls shared between the test tasks and the stream processes
  bit tx_idle_en;
  bit rx_idle_en;
  int hold_left;
  int stall_left;

  // run statistics
  int mismatch_count;
  int pairs_sent;
  int results_seen;
  int invalid_seen;
  int saturated_seen;
  int input_stall_cycles;

  date_difference_days dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling on the whole run, well above the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // calendar predictor
  // --------------------------------------------------------------------------

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // length of a month in a given year, zero for a month that does not exist
  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    int unsigned n;
    if (m == MonthFeb) begin
      n = leap_year(y) ? 29 : 28;
    end else begin
      case (m)
        4, 6, 9, 11:           n = 30;
        1, 3, 5, 7, 8, 10, 12: n = 31;
        default:               n = 0;
      endcase
    end
    return n;
  endfunction

  function automatic bit date_real(input date_t d);
    int unsigned m;
    m = d.month;
    if (d.year == 0 || m < MonthJan || m > MonthDec) return 1'b0;
    return d.day >= 1 && d.day <= month_length(m, d.year);
  endfunction

  // days since a fixed epoch, with the year taken to start on 1 march so
  // that the leap day falls at its end
  function automatic int unsigned serial_day(input date_t d);
    int unsigned m;
    int unsigned yy;
    int unsigned mp;
    m  = d.month;
    yy = (m <= MonthFeb) ? d.year - 1 : d.year;
    mp = (m > MonthFeb) ? m - 3 : m + 9;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d.day;
  endfunction

  function automatic span_t predict_span(input date_t a, input date_t b);
    span_t       s;
    int unsigned na;
    int unsigned nb;
    int unsigned gap;
    s.distance = '0;
    s.invalid  = 1'b1;
    if (date_real(a) && date_real(b)) begin
      na  = serial_day(a);
      nb  = serial_day(b);
      gap = (na >= nb) ? na - nb : nb - na;
      s.invalid  = 1'b0;
      // far-future pairs overflow the 22-bit field and clip
      s.distance = (gap > DistMax) ? DistMax : gap[DistW-1:0];
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic date_t mk_date(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    date_t r;
    r.day   = d[DayW-1:0];
    r.month = m[MonthW-1:0];
    r.year  = y[YearW-1:0];
    return r;
  endfunction

  // first date in the lowest bits, two pad bits on top
  function automatic logic [47:0] pack_pair(input date_t a, input date_t b);
    return {2'b00, b.year, b.month, b.day, a.year, a.month, a.day};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // year spread: ordinary range, beyond 9999, around century boundaries, tiny
  function automatic int unsigned pick_year();
    int r;
    int unsigned y;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      y = $urandom_range(1, 9999);
    end else if (r < 70) begin
      y = $urandom_range(1, 16383);
    end else if (r < 85) begin
      y = $urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1;
    end else begin
      y = $urandom_range(1, 4);
    end
    return y;
  endfunction

  // a real date in the given year, month ends favoured
  function automatic date_t date_in_year(input int unsigned y);
    int unsigned m;
    int unsigned len;
    int unsigned d;
    m   = $urandom_range(1, 12);
    len = month_length(m, y);
    d   = ($urandom_range(0, 99) < 30) ? len : $urandom_range(1, len);
    return mk_date(d, m, y);
  endfunction

  // raw field values, every bit free
  function automatic date_t raw_date();
    return mk_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
  endfunction

  // one slave transaction, with an optional idle gap in front of it
  task automatic send_pair(input date_t a, input date_t b);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_pair(a, b);
    do @(posedge clk); while (!s_axis_tready);
    pairs_sent++;
  endtask

  // stop offering once a test is done
  task automatic release_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random back-pressure, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // predictor feed and result check, both on the rising edge
  // the result is checked before the new expectation is queued; with a
  // pipeline several stages deep the two never belong to the same pair
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    span_t      want;
    date_t      a;
    date_t      b;
    logic [1:0] pad;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_spans.size() == 0) begin
          report_mismatch("unexpected result, day_distance", m_axis_tdata[DistW-1:0], 0);
        end else begin
          want = pending_spans.pop_front();
          if (m_axis_tdata[DistW-1:0] !== want.distance)
            report_mismatch("day_distance", m_axis_tdata[DistW-1:0], want.distance);
          if (m_axis_tuser[0] !== want.invalid)
            report_mismatch("date_invalid", m_axis_tuser[0], want.invalid);
          if (want.invalid) invalid_seen++;
          if (!want.invalid && want.distance == DistMax) saturated_seen++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        {pad, b.year, b.month, b.day, a.year, a.month, a.day} = s_axis_tdata;
        pending_spans.push_back(predict_span(a, b));
      end
      if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // field extremes, leap rule corners, every way a date can be wrong
  task automatic test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // equal dates at both ends of the year range
    send_pair(mk_date(1, 1, 1), mk_date(1, 1, 1));
    send_pair(mk_date(15, 6, 16383), mk_date(15, 6, 16383));
    // the full gregorian span, both orders
    send_pair(mk_date(1, 1, 1), mk_date(31, 12, 9999));
    send_pair(mk_date(31, 12, 9999), mk_date(1, 1, 1));
    // leap day: century divisible by 400, plain century, ordinary years
    send_pair(mk_date(29, 2, 2000), mk_date(1, 3, 2000));
    send_pair(mk_date(29, 2, 1900), mk_date(1, 1, 1900));
    send_pair(mk_date(29, 2, 2004), mk_date(28, 2, 2004));
    send_pair(mk_date(29, 2, 2001), mk_date(1, 1, 2001));
    send_pair(mk_date(28, 2, 2001), mk_date(1, 3, 2001));
    send_pair(mk_date(29, 2, 4), mk_date(29, 2, 8));
    // year and month roll-overs
    send_pair(mk_date(31, 12, 1999), mk_date(1, 1, 2000));
    send_pair(mk_date(31, 7, 2023), mk_date(1, 8, 2023));
    send_pair(mk_date(30, 9, 2024), mk_date(31, 10, 2024));
    send_pair(mk_date(1, 1, 1), mk_date(1, 3, 1));
    // bad months, bad days, year zero, on either side
    send_pair(mk_date(1, 0, 2000), mk_date(1, 1, 2000));
    send_pair(mk_date(1, 1, 2000), mk_date(1, 13, 2000));
    send_pair(mk_date(1, 15, 2000), mk_date(1, 1, 2000));
    send_pair(mk_date(0, 5, 2000), mk_date(1, 5, 2000));
    send_pair(mk_date(1, 4, 2000), mk_date(31, 4, 2000));
    send_pair(mk_date(1, 1, 0), mk_date(1, 1, 1));
    send_pair(mk_date(31, 15, 0), mk_date(31, 15, 0));
    // years past 9999 are real, and far pairs clip at the field maximum
    send_pair(mk_date(1, 1, 10000), mk_date(1, 1, 9999));
    send_pair(mk_date(31, 1, 16383), mk_date(1, 1, 1));
    send_pair(mk_date(1, 1, 1), mk_date(31, 12, 16383));
    release_input();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure_fill();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_left  = 100;
    repeat (30) send_pair(date_in_year(pick_year()), date_in_year(pick_year()));
    release_input();
  endtask

  // well-formed pairs: neighbours in the same or next year, and far apart
  task automatic test_random_valid(input int count);
    date_t a;
    date_t b;
    int    r;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (count) begin
      a = date_in_year(pick_year());
      r = $urandom_range(0, 99);
      if (r < 30) begin
        b = date_in_year(a.year);
      end else if (r < 40 && a.year < 16383) begin
        b = date_in_year(a.year + 1);
      end else begin
        b = date_in_year(pick_year());
      end
      send_pair(a, b);
    end
    release_input();
  endtask

  // unconstrained fields, about half of them rejected
  task automatic test_random_noise(input int count);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (count) send_pair(raw_date(), raw_date());
    release_input();
  endtask

  // a stretch at full rate with no idling on either side
  task automatic test_full_rate(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_pair(date_in_year(pick_year()), date_in_year(pick_year()));
    release_input();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    int guard;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b0;
    hold_left     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure_fill();
    test_random_valid(1200);
    test_random_noise(300);
    test_full_rate(100);

    // drain, then a few cycles for anything stray
    guard = 0;
    while (pending_spans.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_spans.size() != 0) begin
      $display("%0d results never arrived", pending_spans.size());
      $display("Regression FAIL");
      $finish;
    end
    repeat (10) @(posedge clk);

    $display("%0d date pairs sent, %0d results checked, %0d flagged invalid, %0d clipped",
             pairs_sent, results_seen, invalid_seen, saturated_seen);
    $display("input held back for %0d cycles under back-pressure, %0d mismatches",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
